// ===== sv/kalman_cv_tracker_2d_defines.svh =====
// assertion macros used by the tracker controller
`ifndef KALMAN_CV_TRACKER_2D_DEFINES_SVH
`define KALMAN_CV_TRACKER_2D_DEFINES_SVH
`ifndef SYNTHESIS
`define KCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kalman_cv_tracker_2d check failed");
`define KCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kalman_cv_tracker_2d check failed");
`else
`define KCT_ASSERT_NOW(label, ante, cons)
`define KCT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/kct_pkg.sv =====
// shared constants, types, arithmetic helpers and microcode for the tracker
package kct_pkg;

  localparam int VALUE_W  = 48;
  localparam int FRAC     = 16;
  localparam int FIELD_W  = 48;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int LIMB     = VALUE_W / 2;
  localparam int PROD_W   = 2 * VALUE_W;
  localparam int MAG_W    = PROD_W - FRAC;
  localparam int NUM_W    = VALUE_W + FRAC;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W    = 7;

  // command and status codes
  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_PRED = 2'd1;
  localparam logic [1:0] CMD_UPD  = 2'd2;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_SKIP  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IPV = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IVV = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QV  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R   = 3'd4;
  localparam logic [CFG_W-1:0] RST_IPV = 32'd6553600;
  localparam logic [CFG_W-1:0] RST_IVV = 32'd1638400;
  localparam logic [CFG_W-1:0] RST_QP  = 32'd6554;
  localparam logic [CFG_W-1:0] RST_QV  = 32'd65536;
  localparam logic [CFG_W-1:0] RST_R   = 32'd1638400;

  // micro-operation codes
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_LDA    = 4'd0;
  localparam logic [OP_W-1:0] OP_LDB    = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB    = 4'd3;
  localparam logic [OP_W-1:0] OP_MULADD = 4'd4;
  localparam logic [OP_W-1:0] OP_MULSUB = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV    = 4'd6;
  localparam logic [OP_W-1:0] OP_ST     = 4'd7;
  localparam logic [OP_W-1:0] OP_CLRP   = 4'd8;
  localparam logic [OP_W-1:0] OP_CHK    = 4'd9;
  localparam logic [OP_W-1:0] OP_END    = 4'd10;

  // operand addresses: state and covariance, scratch, read-only sources
  localparam int ADDR_W  = 6;
  localparam int NUM_MAIN = 20;
  localparam int MAIN_IW = 5;
  localparam int NUM_TMP = 16;
  localparam int TMP_IW  = 4;
  localparam int A_SV0  = 0;
  localparam int A_P    = 4;
  localparam int A_TMP  = 20;
  localparam int A_K    = 20;
  localparam int A_Y0   = 28;
  localparam int A_Y1   = 29;
  localparam int A_S00  = 30;
  localparam int A_S01  = 31;
  localparam int A_S10  = 32;
  localparam int A_S11  = 33;
  localparam int A_DET  = 34;
  localparam int A_T0   = 35;
  localparam int A_SRC  = 36;
  localparam logic [ADDR_W-1:0] A_INX  = 6'd36;
  localparam logic [ADDR_W-1:0] A_INY  = 6'd37;
  localparam logic [ADDR_W-1:0] A_INVX = 6'd38;
  localparam logic [ADDR_W-1:0] A_INVY = 6'd39;
  localparam logic [ADDR_W-1:0] A_DT   = 6'd40;
  localparam logic [ADDR_W-1:0] A_IPV  = 6'd41;
  localparam logic [ADDR_W-1:0] A_IVV  = 6'd42;
  localparam logic [ADDR_W-1:0] A_QP   = 6'd43;
  localparam logic [ADDR_W-1:0] A_QV   = 6'd44;
  localparam logic [ADDR_W-1:0] A_R    = 6'd45;
  localparam logic [ADDR_W-1:0] A_ZERO = 6'd46;

  // microcode layout
  localparam int PC_W       = 9;
  localparam int ROM_DEPTH  = 296;
  localparam logic [PC_W-1:0] ENTRY_INIT = 9'd0;
  localparam logic [PC_W-1:0] ENTRY_PRED = 9'd16;
  localparam logic [PC_W-1:0] ENTRY_UPD  = 9'd84;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
  } uop_t;

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic              start;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic              load_out;
    logic              skip;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic nonpos;
  } stat_t;

  function automatic uop_t mk(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    uop_t u;
    u.op = op;
    u.addr = addr;
    return u;
  endfunction

  function automatic logic [ADDR_W-1:0] pa(input int i, input int j);
    return ADDR_W'(A_P + 4 * i + j);
  endfunction

  function automatic logic [ADDR_W-1:0] ka(input int i, input int c);
    return ADDR_W'(A_K + 2 * i + c);
  endfunction

  function automatic logic [ADDR_W-1:0] sa(input int i);
    return ADDR_W'(A_SV0 + i);
  endfunction

  // magnitude of a signed value
  function automatic logic [VALUE_W-1:0] mag(input logic [VALUE_W-1:0] v);
    return v[VALUE_W-1] ? (~v + 1'b1) : v;
  endfunction

  // signed add or subtract with clamp; top bit flags a clamp
  function automatic logic [VALUE_W:0] sat_addsub(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b,
                                                  input logic sub);
    logic [VALUE_W:0] s;
    logic [VALUE_W:0] r;
    s = sub ? ({a[VALUE_W-1], a} - {b[VALUE_W-1], b})
            : ({a[VALUE_W-1], a} + {b[VALUE_W-1], b});
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      r = {1'b1, s[VALUE_W], {(VALUE_W-1){~s[VALUE_W]}}};
    end else begin
      r = {1'b0, s[VALUE_W-1:0]};
    end
    return r;
  endfunction

  // sign and magnitude to clamped signed value; top bit flags a clamp
  function automatic logic [VALUE_W:0] from_mag(input logic neg, input logic [MAG_W-1:0] m);
    logic [MAG_W-1:0] lim;
    logic [VALUE_W:0] r;
    lim = MAG_W'({1'b0, {(VALUE_W-1){1'b1}}});
    if (neg) begin
      if (m > lim + 1'b1) r = {1'b1, 1'b1, {(VALUE_W-1){1'b0}}};
      else r = {1'b0, (~m[VALUE_W-1:0] + 1'b1)};
    end else begin
      if (m > lim) r = {1'b1, 1'b0, {(VALUE_W-1){1'b1}}};
      else r = {1'b0, m[VALUE_W-1:0]};
    end
    return r;
  endfunction

  // microprogram: initialize, predict and update sequences
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t rom [ROM_DEPTH];
    uop_t res;
    int n;
    for (int k = 0; k < ROM_DEPTH; k++) rom[k] = mk(OP_END, A_ZERO);
    n = 0;
    // initialize
    for (int i = 0; i < 4; i++) begin
      rom[n] = mk(OP_LDA, A_INX + ADDR_W'(i)); n++;
      rom[n] = mk(OP_ST, sa(i)); n++;
    end
    rom[n] = mk(OP_CLRP, A_ZERO); n++;
    rom[n] = mk(OP_LDA, A_IPV); n++;
    rom[n] = mk(OP_ST, pa(0, 0)); n++;
    rom[n] = mk(OP_ST, pa(1, 1)); n++;
    rom[n] = mk(OP_LDA, A_IVV); n++;
    rom[n] = mk(OP_ST, pa(2, 2)); n++;
    rom[n] = mk(OP_ST, pa(3, 3)); n++;
    rom[n] = mk(OP_END, A_ZERO); n++;
    // predict
    rom[n] = mk(OP_LDB, A_DT); n++;
    for (int i = 0; i < 2; i++) begin
      rom[n] = mk(OP_LDA, sa(i)); n++;
      rom[n] = mk(OP_MULADD, sa(i + 2)); n++;
      rom[n] = mk(OP_ST, sa(i)); n++;
    end
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 2; i++) begin
        rom[n] = mk(OP_LDA, pa(i, j)); n++;
        rom[n] = mk(OP_MULADD, pa(i + 2, j)); n++;
        rom[n] = mk(OP_ST, pa(i, j)); n++;
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int c = 0; c < 2; c++) begin
        rom[n] = mk(OP_LDA, pa(i, c)); n++;
        rom[n] = mk(OP_MULADD, pa(i, c + 2)); n++;
        rom[n] = mk(OP_ST, pa(i, c)); n++;
      end
    end
    for (int d = 0; d < 4; d++) begin
      rom[n] = mk(OP_LDA, pa(d, d)); n++;
      rom[n] = mk(OP_ADD, (d < 2) ? A_QP : A_QV); n++;
      rom[n] = mk(OP_ST, pa(d, d)); n++;
    end
    rom[n] = mk(OP_END, A_ZERO); n++;
    // update: innovation
    for (int i = 0; i < 2; i++) begin
      rom[n] = mk(OP_LDA, A_INX + ADDR_W'(i)); n++;
      rom[n] = mk(OP_SUB, sa(i)); n++;
      rom[n] = mk(OP_ST, ADDR_W'(A_Y0 + i)); n++;
    end
    // innovation covariance
    rom[n] = mk(OP_LDA, pa(0, 0)); n++;
    rom[n] = mk(OP_ADD, A_R); n++;
    rom[n] = mk(OP_ST, ADDR_W'(A_S00)); n++;
    rom[n] = mk(OP_LDA, pa(0, 1)); n++;
    rom[n] = mk(OP_ST, ADDR_W'(A_S01)); n++;
    rom[n] = mk(OP_LDA, pa(1, 0)); n++;
    rom[n] = mk(OP_ST, ADDR_W'(A_S10)); n++;
    rom[n] = mk(OP_LDA, pa(1, 1)); n++;
    rom[n] = mk(OP_ADD, A_R); n++;
    rom[n] = mk(OP_ST, ADDR_W'(A_S11)); n++;
    // determinant and singular check
    rom[n] = mk(OP_LDA, A_ZERO); n++;
    rom[n] = mk(OP_LDB, ADDR_W'(A_S11)); n++;
    rom[n] = mk(OP_MULADD, ADDR_W'(A_S00)); n++;
    rom[n] = mk(OP_LDB, ADDR_W'(A_S10)); n++;
    rom[n] = mk(OP_MULSUB, ADDR_W'(A_S01)); n++;
    rom[n] = mk(OP_ST, ADDR_W'(A_DET)); n++;
    rom[n] = mk(OP_CHK, A_ZERO); n++;
    // gain
    for (int i = 0; i < 4; i++) begin
      rom[n] = mk(OP_LDA, A_ZERO); n++;
      rom[n] = mk(OP_LDB, ADDR_W'(A_S11)); n++;
      rom[n] = mk(OP_MULADD, pa(i, 0)); n++;
      rom[n] = mk(OP_LDB, ADDR_W'(A_S10)); n++;
      rom[n] = mk(OP_MULSUB, pa(i, 1)); n++;
      rom[n] = mk(OP_DIV, ADDR_W'(A_DET)); n++;
      rom[n] = mk(OP_ST, ka(i, 0)); n++;
      rom[n] = mk(OP_LDA, A_ZERO); n++;
      rom[n] = mk(OP_LDB, ADDR_W'(A_S00)); n++;
      rom[n] = mk(OP_MULADD, pa(i, 1)); n++;
      rom[n] = mk(OP_LDB, ADDR_W'(A_S01)); n++;
      rom[n] = mk(OP_MULSUB, pa(i, 0)); n++;
      rom[n] = mk(OP_DIV, ADDR_W'(A_DET)); n++;
      rom[n] = mk(OP_ST, ka(i, 1)); n++;
    end
    // state correction
    for (int i = 0; i < 4; i++) begin
      rom[n] = mk(OP_LDA, A_ZERO); n++;
      rom[n] = mk(OP_LDB, ADDR_W'(A_Y0)); n++;
      rom[n] = mk(OP_MULADD, ka(i, 0)); n++;
      rom[n] = mk(OP_LDB, ADDR_W'(A_Y1)); n++;
      rom[n] = mk(OP_MULADD, ka(i, 1)); n++;
      rom[n] = mk(OP_ADD, sa(i)); n++;
      rom[n] = mk(OP_ST, sa(i)); n++;
    end
    // covariance rows 2 and 3 while rows 0 and 1 are still old
    for (int i = 2; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        rom[n] = mk(OP_LDA, pa(i, j)); n++;
        rom[n] = mk(OP_LDB, ka(i, 0)); n++;
        rom[n] = mk(OP_MULSUB, pa(0, j)); n++;
        rom[n] = mk(OP_LDB, ka(i, 1)); n++;
        rom[n] = mk(OP_MULSUB, pa(1, j)); n++;
        rom[n] = mk(OP_ST, pa(i, j)); n++;
      end
    end
    // rows 0 and 1 column by column, row 0 parked in scratch
    for (int j = 0; j < 4; j++) begin
      rom[n] = mk(OP_LDA, pa(0, j)); n++;
      rom[n] = mk(OP_LDB, ka(0, 0)); n++;
      rom[n] = mk(OP_MULSUB, pa(0, j)); n++;
      rom[n] = mk(OP_LDB, ka(0, 1)); n++;
      rom[n] = mk(OP_MULSUB, pa(1, j)); n++;
      rom[n] = mk(OP_ST, ADDR_W'(A_T0)); n++;
      rom[n] = mk(OP_LDA, pa(1, j)); n++;
      rom[n] = mk(OP_LDB, ka(1, 0)); n++;
      rom[n] = mk(OP_MULSUB, pa(0, j)); n++;
      rom[n] = mk(OP_LDB, ka(1, 1)); n++;
      rom[n] = mk(OP_MULSUB, pa(1, j)); n++;
      rom[n] = mk(OP_ST, pa(1, j)); n++;
      rom[n] = mk(OP_LDA, ADDR_W'(A_T0)); n++;
      rom[n] = mk(OP_ST, pa(0, j)); n++;
    end
    rom[n] = mk(OP_END, A_ZERO);
    if (pc < PC_W'(ROM_DEPTH)) res = rom[pc];
    else res = mk(OP_END, A_ZERO);
    return res;
  endfunction

endpackage

// ===== sv/kct_dp.sv =====
// datapath: register file, accumulator, shared multiplier and divider
module kct_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  kct_pkg::ctl_t                       ctl,
  output kct_pkg::stat_t                      status_o,
  input  logic signed [kct_pkg::FIELD_W-1:0]  in_x,
  input  logic signed [kct_pkg::FIELD_W-1:0]  in_y,
  input  logic signed [kct_pkg::FIELD_W-1:0]  in_vx,
  input  logic signed [kct_pkg::FIELD_W-1:0]  in_vy,
  input  logic [kct_pkg::CFG_W-1:0]           step_time,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kct_pkg::CFG_W-1:0]           cfg_data,
  output logic signed [kct_pkg::FIELD_W-1:0]  est_x,
  output logic signed [kct_pkg::FIELD_W-1:0]  est_y,
  output logic signed [kct_pkg::FIELD_W-1:0]  est_vx,
  output logic signed [kct_pkg::FIELD_W-1:0]  est_vy,
  output logic [1:0]                          status
);
  import kct_pkg::*;

  localparam logic [1:0] RUN_NONE = 2'd0;
  localparam logic [1:0] RUN_MUL  = 2'd1;
  localparam logic [1:0] RUN_DIV  = 2'd2;

  logic [VALUE_W-1:0] main [NUM_MAIN];
  logic [VALUE_W-1:0] tmp [NUM_TMP];
  logic [VALUE_W-1:0] in_x_q, in_y_q, in_vx_q, in_vy_q;
  logic [CFG_W-1:0]   dt_q, ipv, ivv, qp, qv, rn;
  logic [VALUE_W-1:0] acc, breg, mres, rd;
  logic [VALUE_W-1:0] ma, mb;
  logic               mneg, msub;
  logic [PROD_W-1:0]  prod, pp_sh, prod_rnd;
  logic [LIMB-1:0]    la, lb;
  logic [VALUE_W-1:0] pp;
  logic [NUM_W-1:0]   num, quo;
  logic [VALUE_W-1:0] rem, rem_sh, den_ext;
  logic               ge, dneg;
  logic [VALUE_W-1:0] den;
  logic [CNT_W-1:0]   cnt;
  logic [1:0]         run;
  logic               done, sat;
  logic               op_quick, mul_last, div_last;
  logic [ADDR_W-1:0]  tofs;
  logic [VALUE_W:0]   as_r, mul_fm, mul_acc, div_fm;

  assign cfg_ready = 1'b1;
  assign status_o.done = done;
  assign status_o.nonpos = acc[VALUE_W-1] || (acc == '0);
  assign tofs = ctl.addr - ADDR_W'(A_TMP);

  // completion of quick operations and of the multiply and divide units
  assign op_quick = ctl.start && (ctl.op != OP_MULADD) && (ctl.op != OP_MULSUB) &&
                    (ctl.op != OP_DIV);
  assign mul_last = (run == RUN_MUL) && (cnt > CNT_W'(4));
  assign div_last = (run == RUN_DIV) && (cnt >= CNT_W'(DIV_STEPS));

  // operand read port
  always_comb begin
    rd = '0;
    if (ctl.addr < ADDR_W'(A_TMP)) begin
      rd = main[ctl.addr[MAIN_IW-1:0]];
    end else if (ctl.addr < ADDR_W'(A_SRC)) begin
      rd = tmp[tofs[TMP_IW-1:0]];
    end else begin
      case (ctl.addr)
        A_INX:   rd = in_x_q;
        A_INY:   rd = in_y_q;
        A_INVX:  rd = in_vx_q;
        A_INVY:  rd = in_vy_q;
        A_DT:    rd = VALUE_W'(dt_q);
        A_IPV:   rd = VALUE_W'(ipv);
        A_IVV:   rd = VALUE_W'(ivv);
        A_QP:    rd = VALUE_W'(qp);
        A_QV:    rd = VALUE_W'(qv);
        A_R:     rd = VALUE_W'(rn);
        default: rd = '0;
      endcase
    end
  end

  // add and subtract
  assign as_r = sat_addsub(acc, rd, ctl.op == OP_SUB);

  // one limb product per cycle
  assign la = cnt[1] ? ma[VALUE_W-1:LIMB] : ma[LIMB-1:0];
  assign lb = cnt[0] ? mb[VALUE_W-1:LIMB] : mb[LIMB-1:0];
  assign pp = VALUE_W'(la) * VALUE_W'(lb);
  always_comb begin
    case (cnt[1:0])
      2'd0:    pp_sh = PROD_W'(pp);
      2'd3:    pp_sh = PROD_W'(pp) << (2 * LIMB);
      default: pp_sh = PROD_W'(pp) << LIMB;
    endcase
  end
  assign prod_rnd = prod + (PROD_W'(1) << (FRAC - 1));
  assign mul_fm = from_mag(mneg, prod_rnd[PROD_W-1:FRAC]);
  assign mul_acc = sat_addsub(acc, mres, msub);

  // restoring divide step
  assign den_ext = {1'b0, den[VALUE_W-2:0]};
  assign rem_sh = {rem[VALUE_W-2:0], num[NUM_W-1]};
  assign ge = rem_sh >= den_ext;
  assign div_fm = from_mag(dneg, MAG_W'(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_MAIN; k++) main[k] <= '0;
      ipv <= RST_IPV;
      ivv <= RST_IVV;
      qp <= RST_QP;
      qv <= RST_QV;
      rn <= RST_R;
      run <= RUN_NONE;
      done <= 1'b0;
      sat <= 1'b0;
      cnt <= '0;
    end else begin
      done <= op_quick || mul_last || div_last;
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IPV: ipv <= cfg_data;
          REG_IVV: ivv <= cfg_data;
          REG_QP:  qp <= cfg_data;
          REG_QV:  qv <= cfg_data;
          REG_R:   rn <= cfg_data;
          default: ;
        endcase
      end
      // request capture
      if (ctl.capture) begin
        in_x_q <= in_x;
        in_y_q <= in_y;
        in_vx_q <= in_vx;
        in_vy_q <= in_vy;
        dt_q <= step_time;
        sat <= 1'b0;
      end
      // operation issue
      if (ctl.start) begin
        case (ctl.op)
          OP_LDA: begin
            acc <= rd;
          end
          OP_LDB: begin
            breg <= rd;
          end
          OP_ADD, OP_SUB: begin
            acc <= as_r[VALUE_W-1:0];
            if (as_r[VALUE_W]) sat <= 1'b1;
          end
          OP_ST: begin
            if (ctl.addr < ADDR_W'(A_TMP)) main[ctl.addr[MAIN_IW-1:0]] <= acc;
            else tmp[tofs[TMP_IW-1:0]] <= acc;
          end
          OP_CLRP: begin
            for (int k = A_P; k < NUM_MAIN; k++) main[k] <= '0;
          end
          OP_MULADD, OP_MULSUB: begin
            ma <= mag(rd);
            mb <= mag(breg);
            mneg <= rd[VALUE_W-1] ^ breg[VALUE_W-1];
            msub <= (ctl.op == OP_MULSUB);
            prod <= '0;
            cnt <= '0;
            run <= RUN_MUL;
          end
          OP_DIV: begin
            num <= {mag(acc), {FRAC{1'b0}}};
            dneg <= acc[VALUE_W-1];
            den <= rd;
            rem <= '0;
            quo <= '0;
            cnt <= '0;
            run <= RUN_DIV;
          end
          default: ;
        endcase
      end
      // multi-cycle units
      case (run)
        RUN_MUL: begin
          if (cnt < CNT_W'(4)) begin
            prod <= prod + pp_sh;
            cnt <= cnt + 1'b1;
          end else if (cnt == CNT_W'(4)) begin
            mres <= mul_fm[VALUE_W-1:0];
            if (mul_fm[VALUE_W]) sat <= 1'b1;
            cnt <= cnt + 1'b1;
          end else begin
            acc <= mul_acc[VALUE_W-1:0];
            if (mul_acc[VALUE_W]) sat <= 1'b1;
            run <= RUN_NONE;
          end
        end
        RUN_DIV: begin
          if (cnt < CNT_W'(DIV_STEPS)) begin
            rem <= ge ? (rem_sh - den_ext) : rem_sh;
            quo <= {quo[NUM_W-2:0], ge};
            num <= num << 1;
            cnt <= cnt + 1'b1;
          end else begin
            acc <= div_fm[VALUE_W-1:0];
            if (div_fm[VALUE_W]) sat <= 1'b1;
            run <= RUN_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      est_x <= main[A_SV0];
      est_y <= main[A_SV0 + 1];
      est_vx <= main[A_SV0 + 2];
      est_vy <= main[A_SV0 + 3];
      status <= ctl.skip ? ST_SKIP : (sat ? ST_SAT : ST_OK);
    end
  end

endmodule

// ===== sv/kct_ctrl.sv =====
// controller: request handshake, microcode sequencer and result handshake
module kct_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     cmd,
  output logic           out_valid,
  input  logic           out_stall,
  output kct_pkg::ctl_t  ctl,
  input  kct_pkg::stat_t status
);
  import kct_pkg::*;
  `include "kalman_cv_tracker_2d_defines.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_ISSUE  = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]      state;
  logic [PC_W-1:0] pc;
  uop_t            uop_q;
  logic            skip;
  logic            out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // commands to the datapath
  always_comb begin
    ctl.capture = (state == S_IDLE) && in_valid;
    ctl.start = (state == S_ISSUE) && (uop_q.op != OP_END) && (uop_q.op != OP_CHK);
    ctl.op = uop_q.op;
    ctl.addr = uop_q.addr;
    ctl.load_out = (state == S_FINISH) && out_free;
    ctl.skip = skip;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      skip <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result valid
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            skip <= 1'b0;
            case (cmd)
              CMD_INIT: begin
                pc <= ENTRY_INIT;
                state <= S_FETCH;
              end
              CMD_PRED: begin
                pc <= ENTRY_PRED;
                state <= S_FETCH;
              end
              CMD_UPD: begin
                pc <= ENTRY_UPD;
                state <= S_FETCH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_FETCH: begin
          uop_q <= ucode(pc);
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          case (uop_q.op)
            OP_END: state <= S_FINISH;
            OP_CHK: begin
              if (status.nonpos) begin
                skip <= 1'b1;
                state <= S_FINISH;
              end else begin
                pc <= pc + 1'b1;
                state <= S_FETCH;
              end
            end
            default: state <= S_WAIT;
          endcase
        end
        S_WAIT: begin
          if (status.done) begin
            pc <= pc + 1'b1;
            state <= S_FETCH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `KCT_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
  `KCT_ASSERT_NOW(a_done_in_wait, status.done, state == S_WAIT)
  `KCT_ASSERT_NEXT(a_result_after_load, ctl.load_out, out_valid && (state == S_IDLE))

endmodule

// ===== sv/kalman_cv_tracker_2d.sv =====
// top level of the constant-velocity 2-D tracker
//
// channel  direction  handshake              payload
// in       request    in_valid / in_stall    cmd, in_x, in_y, in_vx, in_vy, step_time
// out      result     out_valid / out_stall  est_x, est_y, est_vx, est_vy, status
// cfg      write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request at a time; a request runs a microcode sequence on one shared
// 24x24 limb multiplier and a 1-bit restoring divider; every micro-op is
// fetched and issued, and all but the end and check ops wait for the datapath;
// an unknown command runs no microcode
// synchronous reset clears state, covariance and registers to their defaults
// a finished result waits in the output register under out_stall; the next
// request is taken while it waits, but its own result waits for the slot
module kalman_cv_tracker_2d (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic signed [kct_pkg::FIELD_W-1:0]  in_x,
  input  logic signed [kct_pkg::FIELD_W-1:0]  in_y,
  input  logic signed [kct_pkg::FIELD_W-1:0]  in_vx,
  input  logic signed [kct_pkg::FIELD_W-1:0]  in_vy,
  input  logic [kct_pkg::CFG_W-1:0]           step_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [kct_pkg::FIELD_W-1:0]  est_x,
  output logic signed [kct_pkg::FIELD_W-1:0]  est_y,
  output logic signed [kct_pkg::FIELD_W-1:0]  est_vx,
  output logic signed [kct_pkg::FIELD_W-1:0]  est_vy,
  output logic [1:0]                          status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kct_pkg::CFG_W-1:0]           cfg_data
);
  import kct_pkg::*;

  ctl_t  ctl;
  stat_t dp_status;

  // sequencer
  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .status    (dp_status)
  );

  // arithmetic and storage
  kct_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .status_o  (dp_status),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_vx     (in_vx),
    .in_vy     (in_vy),
    .step_time (step_time),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .est_x     (est_x),
    .est_y     (est_y),
    .est_vx    (est_vx),
    .est_vy    (est_vy),
    .status    (status)
  );

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the constant-velocity 2-D tracker
module tb;
  import kct_pkg::*;

  localparam longint LIM = (64'sd1 <<< 47) - 1;
  localparam int WATCH_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1600;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic [1:0] CMD_BAD = 2'd3;

  typedef struct {
    logic signed [FIELD_W-1:0] x, y, vx, vy;
    logic [1:0] st;
  } est_t;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic [1:0] cmd = CMD_INIT;
  logic signed [FIELD_W-1:0] in_x = '0, in_y = '0, in_vx = '0, in_vy = '0;
  logic [CFG_W-1:0] step_time = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [FIELD_W-1:0] est_x, est_y, est_vx, est_vy;
  logic [1:0] status;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IPV;
  logic [CFG_W-1:0] cfg_data = '0;

  // tracker model state and register copies
  longint trk_s[4];
  longint trk_p[4][4];
  logic [CFG_W-1:0] r_ipv, r_ivv, r_qp, r_qv, r_r;
  bit clamp_hit;
  est_t est_q[$];
  int mismatches = 0;
  int cycle_no = 0, quiet = 0;
  bit calm;

  kalman_cv_tracker_2d dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // quiet stretch with no idling on either side
  assign calm = (cycle_no > 30000) && (cycle_no < 90000);

  // fixed point helpers, clamped to the value range
  function automatic longint clampv(bit neg, logic [127:0] m);
    if (neg) begin
      if (m > 128'(LIM) + 1) begin
        clamp_hit = 1;
        return -LIM - 1;
      end
      return -longint'(m[63:0]);
    end
    if (m > 128'(LIM)) begin
      clamp_hit = 1;
      return LIM;
    end
    return longint'(m[63:0]);
  endfunction

  function automatic logic [127:0] absv(longint a);
    return 128'(a < 0 ? -a : a);
  endfunction

  function automatic longint qadd(longint a, longint b);
    longint s;
    s = a + b;
    return clampv(s < 0, absv(s));
  endfunction

  function automatic longint qsub(longint a, longint b);
    return qadd(a, -b);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    p = (absv(a) * absv(b) + (128'd1 << (FRAC - 1))) >> FRAC;
    return clampv((a < 0) != (b < 0), p);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic [127:0] q;
    q = (absv(n) << FRAC) / 128'(d);
    return clampv(n < 0, q);
  endfunction

  // one command through the tracker model
  function automatic est_t track_step(logic [1:0] c, longint x, longint y, longint vx,
                                      longint vy, logic [CFG_W-1:0] dt_raw);
    est_t e;
    longint a[4][4], old[4][4], k[4][2];
    longint dt, rv, y0, y1, s00, s01, s10, s11, det;
    bit skip;
    clamp_hit = 0;
    skip = 0;
    case (c)
      CMD_INIT: begin
        trk_s[0] = x; trk_s[1] = y; trk_s[2] = vx; trk_s[3] = vy;
        foreach (trk_p[i, j]) trk_p[i][j] = 0;
        trk_p[0][0] = r_ipv; trk_p[1][1] = r_ipv;
        trk_p[2][2] = r_ivv; trk_p[3][3] = r_ivv;
      end
      CMD_PRED: begin
        dt = dt_raw;
        trk_s[0] = qadd(trk_s[0], qmul(trk_s[2], dt));
        trk_s[1] = qadd(trk_s[1], qmul(trk_s[3], dt));
        for (int j = 0; j < 4; j++) begin
          a[0][j] = qadd(trk_p[0][j], qmul(dt, trk_p[2][j]));
          a[1][j] = qadd(trk_p[1][j], qmul(dt, trk_p[3][j]));
          a[2][j] = trk_p[2][j];
          a[3][j] = trk_p[3][j];
        end
        for (int i = 0; i < 4; i++) begin
          trk_p[i][0] = qadd(a[i][0], qmul(dt, a[i][2]));
          trk_p[i][1] = qadd(a[i][1], qmul(dt, a[i][3]));
          trk_p[i][2] = a[i][2];
          trk_p[i][3] = a[i][3];
        end
        trk_p[0][0] = qadd(trk_p[0][0], longint'(r_qp));
        trk_p[1][1] = qadd(trk_p[1][1], longint'(r_qp));
        trk_p[2][2] = qadd(trk_p[2][2], longint'(r_qv));
        trk_p[3][3] = qadd(trk_p[3][3], longint'(r_qv));
      end
      CMD_UPD: begin
        rv = r_r;
        y0 = qsub(x, trk_s[0]);
        y1 = qsub(y, trk_s[1]);
        s00 = qadd(trk_p[0][0], rv);
        s01 = trk_p[0][1];
        s10 = trk_p[1][0];
        s11 = qadd(trk_p[1][1], rv);
        det = qsub(qmul(s00, s11), qmul(s01, s10));
        if (det <= 0) begin
          skip = 1;
        end else begin
          old = trk_p;
          for (int i = 0; i < 4; i++) begin
            k[i][0] = qdiv(qsub(qmul(old[i][0], s11), qmul(old[i][1], s10)), det);
            k[i][1] = qdiv(qsub(qmul(old[i][1], s00), qmul(old[i][0], s01)), det);
            trk_s[i] = qadd(trk_s[i], qadd(qmul(k[i][0], y0), qmul(k[i][1], y1)));
          end
          for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
              trk_p[i][j] = qsub(qsub(old[i][j], qmul(k[i][0], old[0][j])),
                                 qmul(k[i][1], old[1][j]));
        end
      end
      default: ;
    endcase
    e.x = trk_s[0][FIELD_W-1:0];
    e.y = trk_s[1][FIELD_W-1:0];
    e.vx = trk_s[2][FIELD_W-1:0];
    e.vy = trk_s[3][FIELD_W-1:0];
    e.st = skip ? ST_SKIP : (clamp_hit ? ST_SAT : ST_OK);
    return e;
  endfunction

  // send one request; entered and left at a falling edge
  task automatic send(logic [1:0] c, logic signed [FIELD_W-1:0] x, logic signed [FIELD_W-1:0] y,
                      logic signed [FIELD_W-1:0] vx, logic signed [FIELD_W-1:0] vy,
                      logic [CFG_W-1:0] dt);
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c; in_x <= x; in_y <= y; in_vx <= vx; in_vy <= vy; step_time <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    est_q.push_back(track_step(c, longint'(x), longint'(y), longint'(vx), longint'(vy), dt));
    @(negedge clk);
  endtask

  // wait for every expected result, then let the block settle
  task automatic settle();
    in_valid <= 1'b0;
    while (est_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IPV: r_ipv = val;
      REG_IVV: r_ivv = val;
      REG_QP:  r_qp = val;
      REG_QV:  r_qv = val;
      REG_R:   r_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(logic [CFG_W-1:0] ipv, logic [CFG_W-1:0] ivv, logic [CFG_W-1:0] qp,
                         logic [CFG_W-1:0] qv, logic [CFG_W-1:0] rr);
    settle();
    write_reg(REG_IPV, ipv);
    write_reg(REG_IVV, ivv);
    write_reg(REG_QP, qp);
    write_reg(REG_QV, qv);
    write_reg(REG_R, rr);
  endtask

  function automatic logic signed [FIELD_W-1:0] any48();
    return FIELD_W'({$urandom, $urandom});
  endfunction

  function automatic logic signed [FIELD_W-1:0] near48();
    return FIELD_W'(longint'($urandom) - 64'sd2147483648);
  endfunction

  // field extremes, every command, unknown command, saturation
  task automatic test_directed();
    logic signed [FIELD_W-1:0] mx, mn;
    mx = FIELD_W'(LIM);
    mn = FIELD_W'(-LIM - 1);
    send(CMD_UPD, 48'sd65536, -48'sd65536, '0, '0, '0);
    send(CMD_INIT, mx, mn, mx, mn, '0);
    send(CMD_PRED, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send(CMD_UPD, mn, mx, '0, '0, '0);
    send(CMD_BAD, mx, mx, mx, mx, 32'hFFFF_FFFF);
    send(CMD_INIT, 48'sd655360, -48'sd327680, 48'sd65536, -48'sd32768, '0);
    send(CMD_PRED, '0, '0, '0, '0, '0);
    send(CMD_PRED, '0, '0, '0, '0, 32'h0001_0000);
    send(CMD_UPD, 48'sd720000, -48'sd300000, '0, '0, '0);
    send(CMD_UPD, 48'sd700000, -48'sd310000, '0, '0, '0);
    send(CMD_PRED, '0, '0, '0, '0, 32'h0000_8000);
    send(CMD_INIT, '0, '0, '0, '0, '0);
    send(CMD_INIT, -48'sd1, -48'sd1, -48'sd1, -48'sd1, '0);
  endtask

  // zero measurement noise and zero covariance make the innovation singular
  task automatic test_singular();
    set_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send(CMD_INIT, 48'sd65536, 48'sd65536, '0, '0, '0);
    send(CMD_UPD, 48'sd131072, 48'sd0, '0, '0, '0);
    send(CMD_PRED, '0, '0, '0, '0, 32'h0001_0000);
    send(CMD_UPD, 48'sd131072, 48'sd0, '0, '0, '0);
  endtask

  // all registers at full scale
  task automatic test_reg_extremes();
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_INIT, 48'sd100, -48'sd100, 48'sd5, 48'sd5, '0);
    send(CMD_PRED, '0, '0, '0, '0, 32'h0002_0000);
    send(CMD_UPD, 48'sd65536, 48'sd65536, '0, '0, '0);
    send(CMD_UPD, any48(), any48(), '0, '0, '0);
  endtask

  // mostly well-formed tracking runs, some raw noise
  task automatic test_random(int n);
    logic [1:0] c;
    int w;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 199)
        set_all($urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0010_0000),
                $urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0004_0000),
                $urandom_range(1, 32'h0100_0000));
      if ($urandom_range(0, 99) < 12) begin
        c = $urandom_range(0, 3);
        send(c, any48(), any48(), any48(), any48(), $urandom);
      end else begin
        w = $urandom_range(0, 99);
        c = (w < 6) ? CMD_INIT : ((w < 50) ? CMD_PRED : CMD_UPD);
        send(c, near48(), near48(), FIELD_W'(near48() >>> 6), FIELD_W'(near48() >>> 6),
             $urandom_range(0, 32'h0002_0000));
      end
    end
  endtask

  // checker for each accepted result
  always @(posedge clk) begin
    est_t e;
    if (!rst && out_valid && !out_stall) begin
      if (est_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycle_no);
      end else begin
        e = est_q.pop_front();
        if (est_x !== e.x || est_y !== e.y || est_vx !== e.vx || est_vy !== e.vy ||
            status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cycle %0d: exp %0d %0d %0d %0d st %0d got %0d %0d %0d %0d st %0d",
                     cycle_no, e.x, e.y, e.vx, e.vy, e.st,
                     est_x, est_y, est_vx, est_vy, status);
        end
      end
    end
  end

  // result side stalls at random
  always @(negedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 7);

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    foreach (trk_s[i]) trk_s[i] = 0;
    foreach (trk_p[i, j]) trk_p[i][j] = 0;
    r_ipv = RST_IPV; r_ivv = RST_IVV; r_qp = RST_QP; r_qv = RST_QV; r_r = RST_R;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_singular();
    test_reg_extremes();
    set_all(RST_IPV, RST_IVV, RST_QP, RST_QV, RST_R);
    test_random(400);
    settle();
    test_random(420);
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && est_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
